[design/kgrq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgrq_pkg
// Shared types and constants of the keypoint grid radius query block.
// ----------------------------------------------------------------------------
package kgrq_pkg;

  localparam int GRID_COLS_DEF = 64;
  localparam int GRID_ROWS_DEF = 48;
  localparam int MAX_KEYS_DEF  = 1024;
  localparam int CELL_CAP_DEF  = 8;
  localparam int MAX_HITS_DEF  = 64;

  localparam logic [15:0] SCALE_RESET = 16'd6554;
  localparam int          CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 2'd1;

  localparam int KEY_REC_W = 35;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_OUTSIDE    = 2'd1,
    ST_CELL_FULL  = 2'd2,
    ST_STORE_FULL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_CLR,
    B_INS_RD,
    B_INS_WR,
    B_Q_FILL_RD,
    B_Q_FILL,
    B_Q_ENT_RD,
    B_Q_ENT,
    B_Q_KEY,
    B_Q_PUSH,
    B_Q_END,
    B_RESULT
  } back_state_e;

  // one classified command between front and back
  typedef struct packed {
    cmd_e               cmd;
    logic               empty;
    logic [7:0]         cx_lo;
    logic [7:0]         cx_hi;
    logic [7:0]         cy_lo;
    logic [7:0]         cy_hi;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [2:0]         level;
    logic [14:0]        radius;
    logic signed [3:0]  min_level;
    logic signed [3:0]  max_level;
    logic [6:0]         cap;
  } qent_t;

endpackage

[design/keypoint_grid_radius_query.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypoint_grid_radius_query
// Uniform grid of keypoint indices with insert, clear and radius query.
// ----------------------------------------------------------------------------
// The front takes one command at a time and runs inserts and queries through
// its single 18x17 multiplier, then hands the command through a
// two entry queue to the back. The back runs one command at a time against
// three RAMs with registered reads: an insert reads and then writes its cell,
// a query reads the fill count of each cell of its window and each stored
// entry in it, pushes its hits and waits while the result register is
// stalled, and a clear sweeps all
// GRID_COLS*GRID_ROWS fill counters, one per cycle. After reset the same
// sweep runs once before the first command is
// taken; configuration writes are taken at any time.
module keypoint_grid_radius_query import kgrq_pkg::*; #(
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int MAX_KEYS  = MAX_KEYS_DEF,
  parameter int CELL_CAP  = CELL_CAP_DEF,
  parameter int MAX_HITS  = MAX_HITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           cmd_i,
  input  logic signed [15:0]   pos_x_i,
  input  logic signed [15:0]   pos_y_i,
  input  logic [2:0]           level_i,
  input  logic [14:0]          radius_i,
  input  logic signed [3:0]    min_level_i,
  input  logic signed [3:0]    max_level_i,
  input  logic [6:0]           hit_limit_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic                 hit_valid_o,
  output logic [9:0]           key_index_o,
  output logic [6:0]           hit_count_o,
  output logic                 last_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  logic [15:0] scale_x_q, scale_y_q;
  logic  hold, q_full, q_push, q_valid, q_pop;
  qent_t q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q <= SCALE_RESET;
      scale_y_q <= SCALE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SCALE_X: scale_x_q <= cfg_data_i;
        CFG_SCALE_Y: scale_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  kgrq_front #(
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS),
    .MAX_HITS (MAX_HITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .level_i    (level_i),
    .radius_i   (radius_i),
    .min_level_i(min_level_i),
    .max_level_i(max_level_i),
    .hit_limit_i(hit_limit_i),
    .scale_x_i  (scale_x_q),
    .scale_y_i  (scale_y_q),
    .hold_i     (hold),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  kgrq_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  kgrq_back #(
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS),
    .MAX_KEYS (MAX_KEYS),
    .CELL_CAP (CELL_CAP)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .hold_o     (hold),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .hit_valid_o(hit_valid_o),
    .key_index_o(key_index_o),
    .hit_count_o(hit_count_o),
    .last_o     (last_o)
  );

endmodule

[design/kgrq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgrq_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module kgrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/kgrq_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgrq_front
// Accepts commands, scales positions to cell coordinates with one shared
// multiplier and classifies inserts and query windows.
// ----------------------------------------------------------------------------
module kgrq_front import kgrq_pkg::*; #(
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int MAX_HITS  = MAX_HITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [2:0]         level_i,
  input  logic [14:0]        radius_i,
  input  logic signed [3:0]  min_level_i,
  input  logic signed [3:0]  max_level_i,
  input  logic [6:0]         hit_limit_i,
  input  logic [15:0]        scale_x_i,
  input  logic [15:0]        scale_y_i,
  input  logic               hold_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output qent_t              q_data_o
);

  localparam logic signed [15:0] COLS_S = 16'(GRID_COLS);
  localparam logic signed [15:0] ROWS_S = 16'(GRID_ROWS);
  localparam logic [6:0]         HITS_C = 7'(MAX_HITS);
  localparam logic signed [35:0] Q20_MASK = 36'sd1048575;
  localparam logic signed [35:0] Q20_HALF = 36'sd524288;

  front_state_e state_q, state_d;
  logic [2:0]   step_q;
  cmd_e         cmd_q;
  logic signed [15:0] x_q, y_q;
  logic [2:0]   lvl_q;
  logic [14:0]  r_q;
  logic signed [3:0] lo_q, hi_q;
  logic [6:0]   lim_q;
  logic signed [34:0] prod_q;
  logic signed [15:0] v_q [4];

  logic accept;
  logic is_query;
  logic signed [17:0] base, rad, opd;
  logic signed [16:0] scl;
  logic signed [34:0] prod_d;
  logic [1:0]   cstep;
  logic signed [35:0] pe, fl, ce_sum, ce, mag;
  logic [35:0]  rm;
  logic signed [15:0] rnd, conv;

  assign accept   = in_valid_i && !in_stall_o;
  assign is_query = (cmd_q == CMD_QUERY);
  assign cstep    = 2'(step_q - 3'd1);

  // shared multiplier
  always_comb begin
    base = step_q[1] ? 18'(y_q) : 18'(x_q);
    rad  = {3'b000, r_q};
    if (is_query) begin
      opd = step_q[0] ? (base + rad) : (base - rad);
    end else begin
      opd = base;
    end
    scl    = step_q[1] ? {1'b0, scale_y_i} : {1'b0, scale_x_i};
    prod_d = opd * scl;
  end

  // floor, ceil and round of the q20 product
  always_comb begin
    pe     = {prod_q[34], prod_q};
    fl     = pe >>> 20;
    ce_sum = pe + Q20_MASK;
    ce     = ce_sum >>> 20;
    mag    = prod_q[34] ? -pe : pe;
    rm     = 36'(mag + Q20_HALF) >> 20;
    rnd    = prod_q[34] ? -16'(rm[15:0]) : 16'(rm[15:0]);
    if (is_query) begin
      conv = cstep[0] ? ce[15:0] : fl[15:0];
    end else begin
      conv = rnd;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = (cmd_e'(cmd_i) == CMD_INSERT || cmd_e'(cmd_i) == CMD_QUERY) ?
                    F_MUL : F_PUSH;
        end
      end
      F_MUL: begin
        if (step_q == 3'd4) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != F_IDLE) || hold_i;
    q_push_o   = (state_q == F_PUSH) && !q_full_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == F_IDLE) begin
        step_q <= '0;
      end else if (state_q == F_MUL) begin
        step_q <= step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(cmd_i);
      x_q   <= pos_x_i;
      y_q   <= pos_y_i;
      lvl_q <= level_i;
      r_q   <= radius_i;
      lo_q  <= min_level_i;
      hi_q  <= max_level_i;
      lim_q <= hit_limit_i;
    end
    if (state_q == F_MUL) begin
      prod_q <= prod_d;
      if (step_q != 3'd0) begin
        v_q[cstep] <= conv;
      end
    end
  end

  // classification
  logic signed [15:0] cminx, cmaxx, cminy, cmaxy;
  logic [6:0] cap;

  always_comb begin
    cap   = (lim_q > HITS_C) ? HITS_C : lim_q;
    cminx = (v_q[0] < 16'sd0) ? 16'sd0 : v_q[0];
    cmaxx = (v_q[1] >= COLS_S) ? (COLS_S - 16'sd1) : v_q[1];
    cminy = (v_q[2] < 16'sd0) ? 16'sd0 : v_q[2];
    cmaxy = (v_q[3] >= ROWS_S) ? (ROWS_S - 16'sd1) : v_q[3];

    q_data_o           = '0;
    q_data_o.cmd       = cmd_q;
    q_data_o.pos_x     = x_q;
    q_data_o.pos_y     = y_q;
    q_data_o.level     = lvl_q;
    q_data_o.radius    = r_q;
    q_data_o.min_level = lo_q;
    q_data_o.max_level = hi_q;
    q_data_o.cap       = cap;
    case (cmd_q)
      CMD_INSERT: begin
        q_data_o.empty = (v_q[0] < 16'sd0) || (v_q[0] >= COLS_S) ||
                         (v_q[2] < 16'sd0) || (v_q[2] >= ROWS_S);
        q_data_o.cx_lo = v_q[0][7:0];
        q_data_o.cy_lo = v_q[2][7:0];
      end
      CMD_QUERY: begin
        q_data_o.empty = (cminx >= COLS_S) || (cminy >= ROWS_S) ||
                         (cmaxx < cminx) || (cmaxy < cminy) || (cap == 7'd0);
        q_data_o.cx_lo = cminx[7:0];
        q_data_o.cx_hi = cmaxx[7:0];
        q_data_o.cy_lo = cminy[7:0];
        q_data_o.cy_hi = cmaxy[7:0];
      end
      default: q_data_o.empty = 1'b0;
    endcase
  end

endmodule

[design/kgrq_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgrq_queue
// Two entry command queue between front and back.
// ----------------------------------------------------------------------------
module kgrq_queue import kgrq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output qent_t data_o
);

  qent_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

[design/kgrq_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgrq_back
// Executes clear, insert and query commands on the key store, the cell fill
// counts and the cell entry lists, and drives the result register.
// ----------------------------------------------------------------------------
module kgrq_back import kgrq_pkg::*; #(
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int MAX_KEYS  = MAX_KEYS_DEF,
  parameter int CELL_CAP  = CELL_CAP_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  qent_t       q_data_i,
  output logic        q_pop_o,
  output logic        hold_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        hit_valid_o,
  output logic [9:0]  key_index_o,
  output logic [6:0]  hit_count_o,
  output logic        last_o
);

  localparam int NCELLS = GRID_COLS * GRID_ROWS;
  localparam int NENT   = NCELLS * CELL_CAP;
  localparam int KEY_W  = $clog2(MAX_KEYS);
  localparam int KC_W   = $clog2(MAX_KEYS + 1);
  localparam int FILL_W = $clog2(CELL_CAP + 1);
  localparam int CELL_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int ENT_W  = (NENT > 1) ? $clog2(NENT) : 1;

  back_state_e state_q, state_d;
  qent_t       e_q;
  logic [7:0]  cx_q, cy_q;
  logic [FILL_W-1:0] k_q, fill_q;
  logic [6:0]  n_q;
  logic [KEY_W-1:0]  idx_q;
  logic        pend_q;
  logic [KEY_W-1:0]  pend_idx_q;
  logic [6:0]  pend_cnt_q;
  logic [KC_W-1:0]   kc_q;
  logic [CELL_W-1:0] clr_q;
  logic        clr_res_q;
  status_e     res_status_q;
  logic        res_hit_q;
  logic [KEY_W-1:0]  res_idx_q;
  logic [6:0]  res_cnt_q;
  logic        out_valid_q, out_hit_q, out_last_q;
  status_e     out_status_q;
  logic [9:0]  out_idx_q;
  logic [6:0]  out_cnt_q;

  logic [FILL_W-1:0]    fill_rdata;
  logic [KEY_W-1:0]     ent_rdata;
  logic [KEY_REC_W-1:0] key_rdata;

  logic fill_we, ent_we, key_we;
  logic [CELL_W-1:0] fill_waddr;
  logic [FILL_W-1:0] fill_wdata;

  logic [16:0] cell_full;
  logic [CELL_W-1:0] cell_addr;
  logic [22:0] ent_rfull, ent_wfull;
  logic [ENT_W-1:0] ent_raddr, ent_waddr;

  logic out_free, kc_full, cell_full_flag, match;
  logic k_more, y_more, x_more, cap_hit, push_ok;
  logic signed [16:0] dx, dy;
  logic [16:0] adx, ady;
  logic [2:0] kl;
  logic [31:0] res_idx32, pend_idx32;

  assign cell_full  = 17'(cx_q) * 17'(GRID_ROWS) + 17'(cy_q);
  assign cell_addr  = cell_full[CELL_W-1:0];
  assign ent_rfull  = 23'(cell_addr) * 23'(CELL_CAP) + 23'(k_q);
  assign ent_wfull  = 23'(cell_addr) * 23'(CELL_CAP) + 23'(fill_rdata);
  assign ent_raddr  = ent_rfull[ENT_W-1:0];
  assign ent_waddr  = ent_wfull[ENT_W-1:0];

  assign out_free       = !out_valid_q || !out_stall_i;
  assign kc_full        = (kc_q >= KC_W'(MAX_KEYS));
  assign cell_full_flag = (fill_rdata >= FILL_W'(CELL_CAP));
  assign k_more         = (FILL_W'(k_q + 1'b1) < fill_q) && (k_q != fill_q);
  assign y_more         = (cy_q != e_q.cy_hi);
  assign x_more         = (cx_q != e_q.cx_hi);
  assign cap_hit        = (n_q == e_q.cap);
  assign push_ok        = (state_q == B_Q_PUSH) && (!pend_q || out_free);
  assign res_idx32      = 32'(res_idx_q);
  assign pend_idx32     = 32'(pend_idx_q);

  // key test
  always_comb begin
    kl    = key_rdata[2:0];
    dx    = 17'(signed'(key_rdata[34:19])) - 17'(e_q.pos_x);
    dy    = 17'(signed'(key_rdata[18:3])) - 17'(e_q.pos_y);
    adx   = dx[16] ? 17'(-dx) : 17'(dx);
    ady   = dy[16] ? 17'(-dy) : 17'(dy);
    match = (e_q.min_level[3] || (kl >= e_q.min_level[2:0])) &&
            (e_q.max_level[3] || (kl <= e_q.max_level[2:0])) &&
            (adx < {2'b00, e_q.radius}) && (ady < {2'b00, e_q.radius});
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          case (q_data_i.cmd)
            CMD_CLEAR:  state_d = B_CLR;
            CMD_INSERT: state_d = (kc_full || q_data_i.empty) ? B_RESULT : B_INS_RD;
            CMD_QUERY:  state_d = q_data_i.empty ? B_RESULT : B_Q_FILL_RD;
            default:    state_d = B_RESULT;
          endcase
        end
      end
      B_CLR: begin
        if (clr_q == CELL_W'(NCELLS - 1)) begin
          state_d = clr_res_q ? B_RESULT : B_IDLE;
        end
      end
      B_INS_RD:    state_d = B_INS_WR;
      B_INS_WR:    state_d = B_RESULT;
      B_Q_FILL_RD: state_d = B_Q_FILL;
      B_Q_FILL: begin
        if (fill_rdata != '0) begin
          state_d = B_Q_ENT;
        end else begin
          state_d = (y_more || x_more) ? B_Q_FILL_RD : B_Q_END;
        end
      end
      B_Q_ENT_RD: state_d = B_Q_ENT;
      B_Q_ENT:    state_d = B_Q_KEY;
      B_Q_KEY, B_Q_PUSH: begin
        if (state_q == B_Q_KEY && match) begin
          state_d = B_Q_PUSH;
        end else if (state_q == B_Q_KEY || push_ok) begin
          if (cap_hit) begin
            state_d = B_Q_END;
          end else if (k_more) begin
            state_d = B_Q_ENT_RD;
          end else if (y_more || x_more) begin
            state_d = B_Q_FILL_RD;
          end else begin
            state_d = B_Q_END;
          end
        end
      end
      B_Q_END: state_d = B_RESULT;
      B_RESULT: begin
        if (out_free) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    q_pop_o    = (state_q == B_IDLE) && q_valid_i;
    hold_o     = (state_q == B_CLR) && !clr_res_q;
    ent_we     = (state_q == B_INS_WR) && !cell_full_flag;
    key_we     = ent_we;
    fill_we    = (state_q == B_CLR) || ent_we;
    fill_waddr = (state_q == B_CLR) ? clr_q : cell_addr;
    fill_wdata = (state_q == B_CLR) ? '0 : FILL_W'(fill_rdata + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLR;
      clr_q       <= '0;
      clr_res_q   <= 1'b0;
      kc_q        <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      n_q         <= '0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (q_valid_i) begin
            k_q    <= '0;
            n_q    <= '0;
            pend_q <= 1'b0;
            clr_q  <= '0;
            if (q_data_i.cmd == CMD_CLEAR) begin
              clr_res_q <= 1'b1;
              kc_q      <= '0;
            end
          end
        end
        B_CLR: clr_q <= CELL_W'(clr_q + 1'b1);
        B_INS_WR: begin
          if (!cell_full_flag) begin
            kc_q <= KC_W'(kc_q + 1'b1);
          end
        end
        B_Q_FILL: k_q <= '0;
        B_Q_KEY, B_Q_PUSH: begin
          if (state_q == B_Q_KEY && match) begin
            n_q <= n_q + 7'd1;
          end else if (state_q == B_Q_KEY || push_ok) begin
            if (state_q == B_Q_PUSH) begin
              pend_q <= 1'b1;
            end
            if (!cap_hit) begin
              if (k_more) begin
                k_q <= FILL_W'(k_q + 1'b1);
              end else begin
                k_q <= '0;
              end
            end
          end
        end
        default: ;
      endcase
      if (state_q == B_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end
      if (push_ok && pend_q) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          e_q          <= q_data_i;
          cx_q         <= q_data_i.cx_lo;
          cy_q         <= q_data_i.cy_lo;
          res_status_q <= ST_OK;
          res_hit_q    <= 1'b0;
          res_idx_q    <= '0;
          res_cnt_q    <= '0;
          if (q_data_i.cmd == CMD_INSERT) begin
            if (kc_full) begin
              res_status_q <= ST_STORE_FULL;
            end else if (q_data_i.empty) begin
              res_status_q <= ST_OUTSIDE;
            end
          end
        end
      end
      B_INS_WR: begin
        if (cell_full_flag) begin
          res_status_q <= ST_CELL_FULL;
        end else begin
          res_hit_q <= 1'b1;
          res_idx_q <= kc_q[KEY_W-1:0];
        end
      end
      B_Q_FILL: begin
        fill_q <= fill_rdata;
        if (fill_rdata == '0) begin
          if (y_more) begin
            cy_q <= cy_q + 8'd1;
          end else if (x_more) begin
            cx_q <= cx_q + 8'd1;
            cy_q <= e_q.cy_lo;
          end
        end
      end
      B_Q_ENT: idx_q <= ent_rdata;
      B_Q_KEY, B_Q_PUSH: begin
        if (state_q == B_Q_PUSH && push_ok) begin
          pend_idx_q <= idx_q;
          pend_cnt_q <= n_q;
        end
        if ((state_q == B_Q_KEY && !match) || push_ok) begin
          if (!cap_hit && !k_more) begin
            if (y_more) begin
              cy_q <= cy_q + 8'd1;
            end else if (x_more) begin
              cx_q <= cx_q + 8'd1;
              cy_q <= e_q.cy_lo;
            end
          end
        end
      end
      B_Q_END: begin
        res_hit_q <= pend_q;
        res_idx_q <= pend_q ? pend_idx_q : '0;
        res_cnt_q <= pend_q ? pend_cnt_q : 7'd0;
      end
      default: ;
    endcase
    if (state_q == B_RESULT && out_free) begin
      out_status_q <= res_status_q;
      out_hit_q    <= res_hit_q;
      out_idx_q    <= res_idx32[9:0];
      out_cnt_q    <= res_cnt_q;
      out_last_q   <= 1'b1;
    end else if (push_ok && pend_q) begin
      out_status_q <= ST_OK;
      out_hit_q    <= 1'b1;
      out_idx_q    <= pend_idx32[9:0];
      out_cnt_q    <= pend_cnt_q;
      out_last_q   <= 1'b0;
    end
  end

  kgrq_ram #(.WIDTH(FILL_W), .DEPTH(NCELLS)) u_fill_ram (
    .clk_i  (clk_i),
    .we_i   (fill_we),
    .waddr_i(fill_waddr),
    .wdata_i(fill_wdata),
    .raddr_i(cell_addr),
    .rdata_o(fill_rdata)
  );

  kgrq_ram #(.WIDTH(KEY_W), .DEPTH(NENT)) u_ent_ram (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(ent_waddr),
    .wdata_i(kc_q[KEY_W-1:0]),
    .raddr_i(ent_raddr),
    .rdata_o(ent_rdata)
  );

  kgrq_ram #(.WIDTH(KEY_REC_W), .DEPTH(MAX_KEYS)) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(kc_q[KEY_W-1:0]),
    .wdata_i({e_q.pos_x, e_q.pos_y, e_q.level}),
    .raddr_i(ent_rdata),
    .rdata_o(key_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign hit_valid_o = out_hit_q;
  assign key_index_o = out_idx_q;
  assign hit_count_o = out_cnt_q;
  assign last_o      = out_last_q;

  a_kc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kc_q <= KC_W'(MAX_KEYS))
    else $error("key count beyond store size");

  a_ent_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_Q_ENT |-> k_q < fill_q)
    else $error("entry read beyond cell fill");

  a_mid_is_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> out_hit_q && out_status_q == ST_OK)
    else $error("non-final beat without a hit");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_Q_PUSH |-> n_q != 7'd0 && n_q <= e_q.cap)
    else $error("hit count outside cap");

endmodule
